/* src/gtr_pkg.sv */
// ----------------------------------------------------------------------------
// gtr_pkg
// Shared types and constants of the 5x7 glyph text renderer: font table,
// glyph geometry, pen advance and the pixel beat struct.
// ----------------------------------------------------------------------------
package gtr_pkg;

	localparam int GLYPH_COUNT = 21;
	localparam int GLYPH_COLS  = 5;
	localparam int GLYPH_ROWS  = 7;
	localparam int GLYPH_BITS  = GLYPH_COLS * GLYPH_ROWS;

	localparam int ADDR_W  = 18;
	localparam int COORD_X_W = 10;
	localparam int COORD_Y_W = 9;
	localparam int COLOR_W = 8;
	localparam int CODE_W  = 8;

	localparam logic [COORD_X_W:0]   PEN_ADVANCE = (COORD_X_W+1)'(6);
	localparam logic [COORD_X_W-1:0] PEN_X_MAX   = '1;

	localparam logic [2:0] ROW_LAST = 3'(GLYPH_ROWS - 1);

	// bit index = column * 7 + row; each literal lists column 4 down to column 0
	typedef logic [GLYPH_BITS-1:0] glyph_t;

	localparam logic [CODE_W-1:0] GLYPH_CODES [GLYPH_COUNT] = '{
		8'h41, 8'h45, 8'h47, 8'h4D, 8'h4F, 8'h50, 8'h4C, 8'h52, 8'h53, 8'h56,
		8'h30, 8'h31, 8'h32, 8'h33, 8'h34, 8'h35, 8'h36, 8'h37, 8'h38, 8'h39,
		8'h3A
	};

	localparam glyph_t GLYPH_ROM [GLYPH_COUNT] = '{
		{7'h7C, 7'h12, 7'h11, 7'h12, 7'h7C},  // A
		{7'h41, 7'h49, 7'h49, 7'h49, 7'h7F},  // E
		{7'h3A, 7'h49, 7'h49, 7'h41, 7'h3E},  // G
		{7'h7F, 7'h02, 7'h0C, 7'h02, 7'h7F},  // M
		{7'h3E, 7'h41, 7'h41, 7'h41, 7'h3E},  // O
		{7'h06, 7'h09, 7'h09, 7'h09, 7'h7F},  // P
		{7'h40, 7'h40, 7'h40, 7'h40, 7'h7F},  // L
		{7'h46, 7'h29, 7'h19, 7'h09, 7'h7F},  // R
		{7'h32, 7'h49, 7'h49, 7'h49, 7'h26},  // S
		{7'h07, 7'h38, 7'h40, 7'h38, 7'h07},  // V
		{7'h3E, 7'h45, 7'h49, 7'h51, 7'h3E},  // 0
		{7'h00, 7'h40, 7'h7F, 7'h42, 7'h00},  // 1
		{7'h46, 7'h49, 7'h51, 7'h61, 7'h42},  // 2
		{7'h31, 7'h4B, 7'h45, 7'h41, 7'h21},  // 3
		{7'h10, 7'h7F, 7'h12, 7'h14, 7'h18},  // 4
		{7'h39, 7'h45, 7'h45, 7'h45, 7'h27},  // 5
		{7'h30, 7'h49, 7'h49, 7'h4A, 7'h3C},  // 6
		{7'h03, 7'h05, 7'h09, 7'h71, 7'h01},  // 7
		{7'h36, 7'h49, 7'h49, 7'h49, 7'h36},  // 8
		{7'h1E, 7'h29, 7'h49, 7'h49, 7'h06},  // 9
		{7'h00, 7'h00, 7'h36, 7'h36, 7'h00}   // colon
	};

	typedef struct packed {
		logic [ADDR_W-1:0]    addr;
		logic [COORD_X_W-1:0] x;
		logic [COORD_Y_W-1:0] y;
		logic                 last;
	} pix_t;

endpackage

/* src/glyph_text_renderer_unit.sv */
// An accepted character is loaded, then the cell sequencer steps one glyph cell per
//   cycle, up to the last set cell of its bitmap (index at most 34); a set cell
//   holds the step while the pixel side stalls, an empty cell emits nothing. A new
//   character is taken only once the sequencer is idle again.
// Unknown characters emit nothing.
// Reset (arst_n low, asynchronous): pen at (0,0), sequencer idle, output empty.
// ----------------------------------------------------------------------------
// glyph_text_renderer_unit
// 5x7 character generator: draws one character per input beat as a series
// of framebuffer pixel writes, keeping a pen position between characters.
// ----------------------------------------------------------------------------
module glyph_text_renderer_unit
	import gtr_pkg::*;
#(
	parameter int SCREEN_WIDTH_PX = 320
) (
	input  logic        clk,
	input  logic        arst_n,

	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [39:0] s_tdata,   // char_code[7:0], start_x[17:8], start_y[26:18],
	                               // color[34:27], zero pad[39:35]
	input  logic        s_tuser,   // new_string

	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [47:0] m_tdata,   // pixel_address[17:0], pixel_x[27:18],
	                               // pixel_y[36:28], pixel_color[44:37], zero pad[47:45]
	output logic        m_tlast    // last pixel beat of the character
);

	// input beat fields
	logic [CODE_W-1:0]    char_code;
	logic [COORD_X_W-1:0] start_x;
	logic [COORD_Y_W-1:0] start_y;
	logic [COLOR_W-1:0]   color;

	assign char_code = s_tdata[7:0];
	assign start_x   = s_tdata[17:8];
	assign start_y   = s_tdata[26:18];
	assign color     = s_tdata[34:27];

	logic in_beat;
	logic seq_idle;

	assign s_tready = seq_idle;
	assign in_beat  = s_tvalid && s_tready;

	// pen state: loaded on a new string, advanced by 6 after every character
	logic [COORD_X_W-1:0] pen_x_q;
	logic [COORD_Y_W-1:0] pen_y_q;
	logic [COORD_X_W-1:0] draw_x;
	logic [COORD_Y_W-1:0] draw_y;
	logic [COORD_X_W:0]   adv_x;

	assign draw_x = s_tuser ? start_x : pen_x_q;
	assign draw_y = s_tuser ? start_y : pen_y_q;
	assign adv_x  = {1'b0, draw_x} + PEN_ADVANCE;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pen_x_q <= '0;
			pen_y_q <= '0;
		end else if (in_beat) begin
			pen_x_q <= adv_x[COORD_X_W] ? PEN_X_MAX : adv_x[COORD_X_W-1:0];
			pen_y_q <= draw_y;
		end
	end

	// color rides along with the character being drawn
	logic [COLOR_W-1:0] color_q;

	always_ff @(posedge clk) begin
		if (in_beat) color_q <= color;
	end

	glyph_t glyph;

	gtr_glyph_rom u_rom (
		.char_code (char_code),
		.glyph     (glyph)
	);

	logic pix_valid;
	logic pix_ready;
	pix_t pix;

	gtr_raster #(
		.SCREEN_WIDTH_PX (SCREEN_WIDTH_PX)
	) u_raster (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (in_beat),
		.glyph     (glyph),
		.pen_x     (draw_x),
		.pen_y     (draw_y),
		.idle      (seq_idle),
		.pix_valid (pix_valid),
		.pix       (pix),
		.pix_ready (pix_ready)
	);

	// output register: refills in the same cycle the held beat is taken
	logic               out_valid_q;
	pix_t               out_pix_q;
	logic [COLOR_W-1:0] out_color_q;

	assign pix_ready = !out_valid_q || m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (pix_ready) begin
			out_valid_q <= pix_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (pix_ready && pix_valid) begin
			out_pix_q   <= pix;
			out_color_q <= color_q;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tlast  = out_pix_q.last;
	assign m_tdata  = {3'b000, out_color_q, out_pix_q.y, out_pix_q.x, out_pix_q.addr};

endmodule

/* src/gtr_glyph_rom.sv */
// ----------------------------------------------------------------------------
// gtr_glyph_rom
// Maps a character code to its 35-bit column-major bitmap; unknown codes
// give an empty bitmap.
// ----------------------------------------------------------------------------
module gtr_glyph_rom
	import gtr_pkg::*;
(
	input  logic [CODE_W-1:0] char_code,
	output glyph_t            glyph
);

	always_comb begin
		glyph = '0;
		for (int i = 0; i < GLYPH_COUNT; i++) begin
			if (char_code == GLYPH_CODES[i]) begin
				glyph = GLYPH_ROM[i];
			end
		end
	end

endmodule

/* src/gtr_raster.sv */
// ----------------------------------------------------------------------------
// gtr_raster
// Cell sequencer: walks the glyph bitmap column by column, one cell a cycle
// unless pix_ready stalls a set cell; one shared adder steps the address.
// ----------------------------------------------------------------------------
module gtr_raster
	import gtr_pkg::*;
#(
	parameter int SCREEN_WIDTH_PX = 320
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	input  glyph_t               glyph,
	input  logic [COORD_X_W-1:0] pen_x,
	input  logic [COORD_Y_W-1:0] pen_y,
	output logic                 idle,
	output logic                 pix_valid,
	output pix_t                 pix,
	input  logic                 pix_ready
);

	localparam logic [ADDR_W-1:0] ROW_STEP = ADDR_W'(SCREEN_WIDTH_PX);

	typedef enum logic [2:0] {
		ST_IDLE = 3'b001,
		ST_LOAD = 3'b010,
		ST_SCAN = 3'b100
	} state_t;

	state_t               state_q;
	glyph_t               bits_q;
	logic [COORD_X_W-1:0] pen_x_q;
	logic [COORD_Y_W-1:0] pen_y_q;
	logic [2:0]           row_q;
	logic [2:0]           col_q;
	logic [ADDR_W-1:0]    cell_addr_q;
	logic [ADDR_W-1:0]    col_addr_q;

	logic [ADDR_W-1:0] base_addr;
	logic [ADDR_W-1:0] op_a;
	logic [ADDR_W-1:0] op_b;
	logic [ADDR_W-1:0] step_sum;
	logic              col_end;
	logic              cell_done;
	logic              rest_empty;

	// base = pen_y * width + pen_x, kept modulo 2^18
	assign base_addr = ADDR_W'(ADDR_W'(pen_y_q) * ROW_STEP) + ADDR_W'(pen_x_q);

	// shared adder: next row in this column, or top of the next column
	assign col_end  = (row_q == ROW_LAST);
	assign op_a     = col_end ? col_addr_q : cell_addr_q;
	assign op_b     = col_end ? ADDR_W'(1) : ROW_STEP;
	assign step_sum = op_a + op_b;

	assign rest_empty = (bits_q[GLYPH_BITS-1:1] == '0);
	assign cell_done  = (state_q == ST_SCAN) && (!bits_q[0] || pix_ready);

	assign idle      = (state_q == ST_IDLE);
	assign pix_valid = (state_q == ST_SCAN) && bits_q[0];
	assign pix.addr  = cell_addr_q;
	assign pix.x     = pen_x_q + COORD_X_W'(col_q);
	assign pix.y     = pen_y_q + COORD_Y_W'(row_q);
	assign pix.last  = rest_empty;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (start) state_q <= ST_LOAD;
				end
				ST_LOAD: begin
					state_q <= (bits_q == '0) ? ST_IDLE : ST_SCAN;
				end
				ST_SCAN: begin
					if (cell_done && rest_empty) state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (idle && start) begin
			bits_q  <= glyph;
			pen_x_q <= pen_x;
			pen_y_q <= pen_y;
		end
		if (state_q == ST_LOAD) begin
			cell_addr_q <= base_addr;
			col_addr_q  <= base_addr;
			row_q       <= '0;
			col_q       <= '0;
		end else if (cell_done) begin
			bits_q      <= bits_q >> 1;
			cell_addr_q <= step_sum;
			if (col_end) begin
				col_addr_q <= step_sum;
				row_q      <= '0;
				col_q      <= col_q + 3'd1;
			end else begin
				row_q <= row_q + 3'd1;
			end
		end
	end

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		pix_valid && !pix_ready |=> pix_valid && $stable(pix))
		else $error("pixel changed while stalled");

	a_load_once: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_LOAD |=> state_q != ST_LOAD)
		else $error("load state repeated");

	a_last_ends: assert property (@(posedge clk) disable iff (!arst_n)
		pix_valid && pix_ready && pix.last |=> state_q == ST_IDLE)
		else $error("scan continued after last pixel");

	a_start: assert property (@(posedge clk) disable iff (!arst_n)
		idle && start |=> state_q == ST_LOAD)
		else $error("start not taken");

endmodule

/* dv/tb_glyph_text_renderer_unit.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_glyph_text_renderer_unit
// Self-checking bench for the 5x7 glyph text renderer. A table of directed
// characters, then random strings, are pushed in bursts while the pixel side
// stalls on its own pattern. Every pixel beat is matched field by field
// against a local pen/font model in arrival order.
// ----------------------------------------------------------------------------
module tb_glyph_text_renderer_unit;
	import gtr_pkg::*;

	localparam int SCREEN_W   = 320;
	localparam int FONT_N     = 21;
	localparam int PEN_STEP   = 6;
	localparam int PEN_LIMIT  = 1023;
	localparam int RAND_ITEMS = 420;
	localparam int PAUSE_AT   = 300;   // random beat index where the sender drains the block
	localparam int HOLD_AT    = 150;   // accepted chars before the long pixel-side hold-off
	localparam int LONG_HOLD  = 400;   // cycles of that hold-off
	localparam int DRAIN_CYC  = 64;    // tail wait: covers the pipeline and the slowest char, with margin
	localparam int IDLE_LIMIT = 4000;  // cycles with no beat on either side

	// one character beat on the slave side
	typedef struct packed {
		logic [CODE_W-1:0]    code;
		logic                 ns;       // new_string
		logic [COORD_X_W-1:0] sx;
		logic [COORD_Y_W-1:0] sy;
		logic [COLOR_W-1:0]   color;
	} char_t;

	// one framebuffer write on the master side
	typedef struct packed {
		logic [ADDR_W-1:0]    addr;
		logic [COORD_X_W-1:0] x;
		logic [COORD_Y_W-1:0] y;
		logic [COLOR_W-1:0]   color;
		logic                 last;
	} pixel_t;

	// directed row: the char plus, where pinned, pixel count and first pixel
	typedef struct packed {
		logic [CODE_W-1:0]    code;
		logic                 ns;
		logic [COORD_X_W-1:0] sx;
		logic [COORD_Y_W-1:0] sy;
		logic [COLOR_W-1:0]   color;
		logic                 pinned;
		logic [5:0]           n_pix;
		logic [ADDR_W-1:0]    f_addr;
		logic [COORD_X_W-1:0] f_x;
		logic [COORD_Y_W-1:0] f_y;
	} dir_row_t;

	// font, columns listed left to right, bit r of a column is row r
	typedef logic [0:4][6:0] font_glyph_t;

	localparam logic [7:0] FONT_CODE [FONT_N] = '{
		"A", "E", "G", "M", "O", "P", "L", "R", "S", "V",
		"0", "1", "2", "3", "4", "5", "6", "7", "8", "9", ":"
	};

	localparam font_glyph_t FONT_BITS [FONT_N] = '{
		{7'h7C, 7'h12, 7'h11, 7'h12, 7'h7C},
		{7'h7F, 7'h49, 7'h49, 7'h49, 7'h41},
		{7'h3E, 7'h41, 7'h49, 7'h49, 7'h3A},
		{7'h7F, 7'h02, 7'h0C, 7'h02, 7'h7F},
		{7'h3E, 7'h41, 7'h41, 7'h41, 7'h3E},
		{7'h7F, 7'h09, 7'h09, 7'h09, 7'h06},
		{7'h7F, 7'h40, 7'h40, 7'h40, 7'h40},
		{7'h7F, 7'h09, 7'h19, 7'h29, 7'h46},
		{7'h26, 7'h49, 7'h49, 7'h49, 7'h32},
		{7'h07, 7'h38, 7'h40, 7'h38, 7'h07},
		{7'h3E, 7'h51, 7'h49, 7'h45, 7'h3E},
		{7'h00, 7'h42, 7'h7F, 7'h40, 7'h00},
		{7'h42, 7'h61, 7'h51, 7'h49, 7'h46},
		{7'h21, 7'h41, 7'h45, 7'h4B, 7'h31},
		{7'h18, 7'h14, 7'h12, 7'h7F, 7'h10},
		{7'h27, 7'h45, 7'h45, 7'h45, 7'h39},
		{7'h3C, 7'h4A, 7'h49, 7'h49, 7'h30},
		{7'h01, 7'h71, 7'h09, 7'h05, 7'h03},
		{7'h36, 7'h49, 7'h49, 7'h49, 7'h36},
		{7'h06, 7'h49, 7'h49, 7'h29, 7'h1E},
		{7'h00, 7'h36, 7'h36, 7'h00, 7'h00}
	};

	localparam int DIR_N = 26;

	// code, new_string, x, y, color | pinned, pixels, first addr, first x, first y
	localparam dir_row_t DIR_ROWS [DIR_N] = '{
		// pen at (0,0) straight out of reset
		'{":",   1'b0, 10'd0,    9'd0,   8'h5A, 1'b1, 6'd8,  18'd321,    10'd1,    9'd1},
		// unknown code: nothing drawn, pen still moves
		'{8'h00, 1'b0, 10'd0,    9'd0,   8'h00, 1'b1, 6'd0,  18'd0,      10'd0,    9'd0},
		'{"A",   1'b1, 10'd0,    9'd0,   8'h00, 1'b1, 6'd16, 18'd640,    10'd0,    9'd2},
		// pen at the far corner, rows wrap past 511
		'{"8",   1'b1, 10'd1023, 9'd511, 8'hFF, 1'b1, 6'd17, 18'd164863, 10'd1023, 9'd0},
		// pen x stays saturated at 1023
		'{"8",   1'b0, 10'd0,    9'd0,   8'hFF, 1'b1, 6'd17, 18'd164863, 10'd1023, 9'd0},
		// unknown code with all fields at their max
		'{8'hFF, 1'b1, 10'd1023, 9'd511, 8'hFF, 1'b1, 6'd0,  18'd0,      10'd0,    9'd0},
		'{"E",   1'b1, 10'd5,    9'd5,   8'h01, 1'b0, 6'd0,  18'd0,      10'd0,    9'd0},
		'{"G",   1'b0, 10'd0,    9'd0,   8'h02, 1'b0, 6'd0,  18'd0,      10'd0,    9'd0},
		'{"M",   1'b0, 10'd0,    9'd0,   8'h04, 1'b0, 6'd0,  18'd0,      10'd0,    9'd0},
		'{"O",   1'b0, 10'd0,    9'd0,   8'h08, 1'b0, 6'd0,  18'd0,      10'd0,    9'd0},
		'{"P",   1'b0, 10'd0,    9'd0,   8'h10, 1'b0, 6'd0,  18'd0,      10'd0,    9'd0},
		'{"L",   1'b0, 10'd0,    9'd0,   8'h20, 1'b0, 6'd0,  18'd0,      10'd0,    9'd0},
		'{"R",   1'b0, 10'd0,    9'd0,   8'h40, 1'b0, 6'd0,  18'd0,      10'd0,    9'd0},
		'{"S",   1'b0, 10'd0,    9'd0,   8'h80, 1'b0, 6'd0,  18'd0,      10'd0,    9'd0},
		'{"V",   1'b0, 10'd0,    9'd0,   8'h33, 1'b0, 6'd0,  18'd0,      10'd0,    9'd0},
		// crosses the right edge of the screen: no clipping, address runs on
		'{"0",   1'b1, 10'd318,  9'd200, 8'hC3, 1'b0, 6'd0,  18'd0,      10'd0,    9'd0},
		'{"1",   1'b0, 10'd0,    9'd0,   8'h3C, 1'b0, 6'd0,  18'd0,      10'd0,    9'd0},
		'{"2",   1'b0, 10'd0,    9'd0,   8'h55, 1'b0, 6'd0,  18'd0,      10'd0,    9'd0},
		'{"3",   1'b0, 10'd0,    9'd0,   8'hAA, 1'b0, 6'd0,  18'd0,      10'd0,    9'd0},
		'{"4",   1'b0, 10'd0,    9'd0,   8'h0F, 1'b0, 6'd0,  18'd0,      10'd0,    9'd0},
		'{"5",   1'b0, 10'd0,    9'd0,   8'hF0, 1'b0, 6'd0,  18'd0,      10'd0,    9'd0},
		'{"6",   1'b0, 10'd0,    9'd0,   8'h99, 1'b0, 6'd0,  18'd0,      10'd0,    9'd0},
		'{"7",   1'b0, 10'd0,    9'd0,   8'h66, 1'b0, 6'd0,  18'd0,      10'd0,    9'd0},
		'{"9",   1'b0, 10'd0,    9'd0,   8'h7E, 1'b0, 6'd0,  18'd0,      10'd0,    9'd0},
		// x wraps past 1023 and y past 511 inside one glyph
		'{":",   1'b1, 10'd1022, 9'd509, 8'h81, 1'b0, 6'd0,  18'd0,      10'd0,    9'd0},
		// lower case is not in the font
		'{"a",   1'b0, 10'd0,    9'd0,   8'hE7, 1'b0, 6'd0,  18'd0,      10'd0,    9'd0}
	};

	logic        clk;
	logic        arst_n   = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [39:0] s_tdata  = '0;   // char_code, start_x, start_y, color, zero pad
	logic        s_tuser  = 1'b0; // new_string
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [47:0] m_tdata;         // pixel_address, pixel_x, pixel_y, pixel_color, zero pad
	logic        m_tlast;

	pixel_t pixel_q [$];          // pixel writes still owed by the block, oldest first
	int     pen_col   = 0;        // model pen, tracks the block's pen
	int     pen_row   = 0;
	int     chars_in  = 0;        // character beats accepted so far
	int     mismatches = 0;

	glyph_text_renderer_unit #(
		.SCREEN_WIDTH_PX(SCREEN_W)
	) dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata (s_tdata),
		.s_tuser (s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata (m_tdata),
		.m_tlast (m_tlast)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	function automatic void note_mismatch(input string msg);
		mismatches++;
		if (mismatches <= 10) begin
			$display("%s", msg);
		end
	endfunction

	// Draw one char on the model: move the pen, scan the glyph column by
	// column, top row first, queue one write per set bit, then advance.
	function automatic int render_char(input char_t ch);
		int     g;
		int     n;
		int     i;
		int     ci;
		int     ri;
		int     px;
		int     py;
		pixel_t p;
		g = -1;
		n = 0;
		if (ch.ns) begin
			pen_col = ch.sx;
			pen_row = ch.sy;
		end
		for (i = 0; i < FONT_N; i++) begin
			if (g < 0 && FONT_CODE[i] == ch.code) begin
				g = i;
			end
		end
		if (g >= 0) begin
			for (ci = 0; ci < 5; ci++) begin
				for (ri = 0; ri < 7; ri++) begin
					if (FONT_BITS[g][ci][ri]) begin
						px      = pen_col + ci;
						py      = pen_row + ri;
						// full-width math, truncated only at the port widths
						p.addr  = ADDR_W'(py * SCREEN_W + px);
						p.x     = COORD_X_W'(px);
						p.y     = COORD_Y_W'(py);
						p.color = ch.color;
						p.last  = 1'b0;
						pixel_q.push_back(p);
						n++;
					end
				end
			end
		end
		if (n > 0) begin
			p      = pixel_q.pop_back();
			p.last = 1'b1;
			pixel_q.push_back(p);
		end
		pen_col = (pen_col + PEN_STEP > PEN_LIMIT) ? PEN_LIMIT : pen_col + PEN_STEP;
		return n;
	endfunction

	// Random char: mostly glyphs inside strings that start now and then,
	// with some unknown codes and some pens parked near the far corner.
	function automatic char_t rand_char();
		char_t ch;
		ch.code  = ($urandom_range(0, 3) != 0) ? FONT_CODE[$urandom_range(0, FONT_N - 1)]
		                                        : CODE_W'($urandom);
		ch.ns    = ($urandom_range(0, 4) == 0);
		ch.sx    = COORD_X_W'($urandom);
		ch.sy    = COORD_Y_W'($urandom);
		ch.color = COLOR_W'($urandom);
		if ($urandom_range(0, 7) == 0) begin
			ch.sx = COORD_X_W'($urandom_range(1000, 1023));
			ch.sy = COORD_Y_W'($urandom_range(500, 511));
		end
		return ch;
	endfunction

	// Offer one char beat after 'gap' idle cycles and hold it until taken.
	// valid is only lowered when a gap follows, so it never toggles within a step.
	task automatic send_char(input char_t ch, input int gap);
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= {5'b0, ch.color, ch.sy, ch.sx, ch.code};
		s_tuser  <= ch.ns;
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		chars_in++;
	endtask

	// Pixel-side monitor: each accepted beat is matched against the oldest
	// queued write. Sampled at the edge, so it sees pre-edge values.
	always @(posedge clk) begin
		pixel_t want;
		pixel_t got;
		if (arst_n && m_tvalid && m_tready) begin
			got.addr  = m_tdata[17:0];
			got.x     = m_tdata[27:18];
			got.y     = m_tdata[36:28];
			got.color = m_tdata[44:37];
			got.last  = m_tlast;
			if (pixel_q.size() == 0) begin
				note_mismatch($sformatf("unexpected pixel beat addr=%0d x=%0d y=%0d c=%02h l=%0b",
					got.addr, got.x, got.y, got.color, got.last));
			end else begin
				want = pixel_q.pop_front();
				if (got.addr != want.addr || got.x != want.x || got.y != want.y ||
				    got.color != want.color || got.last != want.last) begin
					note_mismatch($sformatf(
						"pixel mismatch exp addr=%0d x=%0d y=%0d c=%02h l=%0b got addr=%0d x=%0d y=%0d c=%02h l=%0b",
						want.addr, want.x, want.y, want.color, want.last,
						got.addr, got.x, got.y, got.color, got.last));
				end
			end
		end
	end

	// Pixel-side backpressure: runs of always-ready, coin-flip and mostly
	// stalled, plus one long hold-off so the block backs up into s_tready.
	initial begin
		int  mode;
		int  mode_left;
		bit  held;
		mode      = 0;
		mode_left = 0;
		held      = 1'b0;
		wait (arst_n);
		forever begin
			@(posedge clk);
			if (!held && chars_in >= HOLD_AT) begin
				held = 1'b1;
				m_tready <= 1'b0;
				repeat (LONG_HOLD) @(posedge clk);
			end else begin
				if (mode_left == 0) begin
					mode      = $urandom_range(0, 2);
					mode_left = $urandom_range(5, 60);
				end
				mode_left--;
				case (mode)
					0: m_tready <= 1'b1;
					1: m_tready <= 1'($urandom_range(0, 1));
					default: m_tready <= ($urandom_range(0, 3) == 0);
				endcase
			end
		end
	end

	// Watchdog: a long run of cycles with no beat on either side is a hang.
	initial begin
		int idle_cycles;
		idle_cycles = 0;
		while (idle_cycles < IDLE_LIMIT) begin
			@(posedge clk);
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
				idle_cycles = 0;
			end else begin
				idle_cycles++;
			end
		end
		$display("SCOREBOARD MISMATCH");
		$finish;
	end

	// Stimulus: reset, directed table, random bursts, drain, verdict.
	initial begin
		char_t  ch;
		pixel_t first;
		int     r;
		int     n;
		int     k;
		int     burst;
		int     gap;
		int     sent;
		bit     paused;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (r = 0; r < DIR_N; r++) begin
			ch.code  = DIR_ROWS[r].code;
			ch.ns    = DIR_ROWS[r].ns;
			ch.sx    = DIR_ROWS[r].sx;
			ch.sy    = DIR_ROWS[r].sy;
			ch.color = DIR_ROWS[r].color;
			send_char(ch, $urandom_range(0, 2));
			n = render_char(ch);
			// pinned rows: pixel count and first write are known by hand
			if (DIR_ROWS[r].pinned) begin
				if (n != DIR_ROWS[r].n_pix) begin
					note_mismatch($sformatf("row %0d: exp %0d pixels, model gives %0d",
						r, DIR_ROWS[r].n_pix, n));
				end else if (n > 0) begin
					first = pixel_q[pixel_q.size() - n];
					if (first.addr != DIR_ROWS[r].f_addr || first.x != DIR_ROWS[r].f_x ||
					    first.y != DIR_ROWS[r].f_y) begin
						note_mismatch($sformatf("row %0d: exp first %0d/%0d/%0d got %0d/%0d/%0d",
							r, DIR_ROWS[r].f_addr, DIR_ROWS[r].f_x, DIR_ROWS[r].f_y,
							first.addr, first.x, first.y));
					end
				end
			end
		end

		sent   = 0;
		paused = 1'b0;
		while (sent < RAND_ITEMS) begin
			burst = $urandom_range(1, 24);
			gap   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
			// once, let the block run dry before going on
			if (!paused && sent >= PAUSE_AT) begin
				paused = 1'b1;
				s_tvalid <= 1'b0;
				do @(posedge clk); while (pixel_q.size() != 0);
			end
			for (k = 0; k < burst && sent < RAND_ITEMS; k++) begin
				ch = rand_char();
				send_char(ch, (k == 0) ? gap : 0);
				void'(render_char(ch));
				sent++;
			end
		end
		s_tvalid <= 1'b0;

		while (pixel_q.size() != 0) @(posedge clk);
		// tail: catch any beat the block emits past the last expected one
		repeat (DRAIN_CYC) @(posedge clk);

		if (mismatches == 0) begin
			$display("SCOREBOARD CLEAN");
		end else begin
			$display("SCOREBOARD MISMATCH");
		end
		$finish;
	end

endmodule

/* glyph_text_renderer_unit.f */
src/gtr_pkg.sv
src/gtr_glyph_rom.sv
src/gtr_raster.sv
src/glyph_text_renderer_unit.sv
dv/tb_glyph_text_renderer_unit.sv
